// ===== design/brpk_pkg.sv =====
// shared constants and types for the byte ring packetizer
// no dependencies; imported by byte_ring_packetizer_timeout_flush_top
package brpk_pkg;

  // ring geometry
  localparam int RING_DEPTH    = 256;
  localparam int PTR_W         = $clog2(RING_DEPTH);

  // packet geometry: one length byte then the payload slots
  localparam int PAYLOAD_BYTES = 63;
  localparam int LEN_W         = $clog2(PAYLOAD_BYTES + 1);

  // field widths
  localparam int DATA_W        = 8;
  localparam int WAIT_W        = 8;

  localparam logic [WAIT_W-1:0] TIMEOUT_RESET = WAIT_W'(5);

  // request function codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

endpackage

// ===== design/byte_ring_packetizer_timeout_flush_top.sv =====
// byte ring packetizer with timeout flush: ring memory, pointers and packet sequencer
// depends on brpk_pkg for geometry constants, function codes and the state type
//
// Usage
//   Request channel: func, data_byte are taken at a rising edge with start high and busy
//   low. func = push writes data_byte into the 256-entry ring (dropped when 255 bytes are
//   already held); func = tick polls the ring.
//   Result channel: out_byte and last are shown for one cycle each, marked by strobe.
//   The receiver cannot stall, so a packet streams out with no gaps.
//   Configuration: cfg_write high at a rising edge loads cfg_data into the flush timeout.
// Request and result flow
//   A push, or a tick that sends nothing, keeps busy low, and the next request can
//   follow in the next cycle.
//   A tick that sends a packet gives the length byte in the cycle after it is taken, then
//   63 payload or padding bytes, one per cycle. busy is high while the ring memory port
//   walks the packet; it drops as the last byte is shown, when a new request is taken.
// Reset
//   rst (synchronous) empties the ring, clears the wait counter, sets the timeout to 5
//   and stops any packet in flight. The ring memory itself is not cleared.
module byte_ring_packetizer_timeout_flush_top
  import brpk_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              func,
  input  logic [DATA_W-1:0] data_byte,
  input  logic              cfg_write,
  input  logic [WAIT_W-1:0] cfg_data,
  output logic              strobe,
  output logic [DATA_W-1:0] out_byte,
  output logic              last
);

  // ring memory and its read port
  logic [DATA_W-1:0] ring [RING_DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [PTR_W-1:0]  rd_addr;

  // control state
  state_t            state;
  logic [PTR_W-1:0]  rp;
  logic [PTR_W-1:0]  wp;
  logic [WAIT_W-1:0] wait_count;
  logic [WAIT_W-1:0] flush_timeout;
  logic [LEN_W-1:0]  cnt;
  logic [LEN_W-1:0]  plen;

  // decoded request
  logic              accept;
  logic              is_push;
  logic [PTR_W-1:0]  held;
  logic              ring_full;
  logic              ring_empty;
  logic              has_full;
  logic [WAIT_W-1:0] wait_inc;
  logic              flush_hit;
  logic              emit_go;
  logic              last_slot;
  logic [LEN_W-1:0]  plen_next;

  assign busy = (state == ST_EMIT);

  // request decode and packet decision
  always_comb begin
    accept     = start && !busy;
    is_push    = (func == FUNC_PUSH);
    held       = wp - rp;
    ring_full  = (held == PTR_W'(RING_DEPTH - 1));
    ring_empty = (held == '0);
    has_full   = (held >= PTR_W'(PAYLOAD_BYTES));
    wait_inc   = wait_count + WAIT_W'(1);
    flush_hit  = (wait_inc == flush_timeout);
    emit_go    = accept && !is_push && !ring_empty && (has_full || flush_hit);
    plen_next  = has_full ? LEN_W'(PAYLOAD_BYTES) : held[LEN_W-1:0];
    last_slot  = (cnt == LEN_W'(PAYLOAD_BYTES - 1));
  end

  // read address runs one slot ahead of the byte being registered for output
  always_comb begin
    if (state == ST_EMIT) begin
      rd_addr = rp + PTR_W'(cnt) + PTR_W'(1);
    end else begin
      rd_addr = rp;
    end
  end

  // ring memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (accept && is_push && !ring_full) begin
      ring[wp] <= data_byte;
    end
    rd_data <= ring[rd_addr];
  end

  // pointers, wait counter, timeout and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      rp            <= '0;
      wp            <= '0;
      wait_count    <= '0;
      flush_timeout <= TIMEOUT_RESET;
      cnt           <= '0;
    end else begin
      if (cfg_write) begin
        flush_timeout <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && is_push) begin
            if (!ring_full) begin
              wp <= wp + PTR_W'(1);
            end
          end else if (accept && !ring_empty) begin
            if (has_full || flush_hit) begin
              wait_count <= '0;
            end else begin
              wait_count <= wait_inc;
            end
            if (emit_go) begin
              state <= ST_EMIT;
              cnt   <= '0;
            end
          end
        end
        ST_EMIT: begin
          cnt <= cnt + LEN_W'(1);
          if (last_slot) begin
            state <= ST_IDLE;
            rp    <= rp + PTR_W'(plen);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // packet length latch
  always_ff @(posedge clk) begin
    if (emit_go) begin
      plen <= plen_next;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit_go || busy;
    end
  end

  // result payload: length byte first, then ring bytes or zero padding
  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_byte <= DATA_W'(plen_next);
      last     <= (PAYLOAD_BYTES == 0);
    end else if (busy) begin
      out_byte <= (cnt < plen) ? rd_data : '0;
      last     <= last_slot;
    end else begin
      out_byte <= '0;
      last     <= 1'b0;
    end
  end

  // last byte only appears inside a strobed cycle
  assert property (@(posedge clk) disable iff (rst) last |-> strobe)
    else $error("last without strobe");

  // a packet in flight shows a byte every cycle
  assert property (@(posedge clk) disable iff (rst) busy |=> strobe)
    else $error("gap in packet stream");

  // no ring write while a packet is being walked
  assert property (@(posedge clk) disable iff (rst) busy |=> $stable(wp))
    else $error("write pointer moved during packet");

  // every byte but the last is shown while the sequencer runs
  assert property (@(posedge clk) disable iff (rst) (strobe && !last) |-> busy)
    else $error("packet byte outside sequencer run");

  // the length byte goes out as the sequencer starts
  assert property (@(posedge clk) disable iff (rst) $rose(busy) |-> strobe)
    else $error("sequencer started without length byte");

endmodule
